[hdl/rhwf_pkg.sv]
package rhwf_pkg;

  localparam int unsigned MazeDim  = 32;
  localparam int unsigned CoordW   = 5;
  localparam int unsigned SizeW    = 6;
  localparam int unsigned HeadW    = 2;
  localparam int unsigned CmpW     = 8;
  localparam int unsigned MapDepth = MazeDim * MazeDim;
  localparam int unsigned AddrW    = $clog2(MapDepth);
  localparam int unsigned SizeCap  = (MazeDim < 32) ? MazeDim : 32;
  localparam int unsigned SizeMin  = 3;

  localparam logic [SizeW-1:0]  ResetSize    = SizeW'(32);
  localparam logic [CoordW-1:0] ResetStartX  = CoordW'(30);
  localparam logic [CoordW-1:0] ResetStartY  = CoordW'(30);
  localparam logic [1:0]        LastTry      = 2'd3;

  typedef enum logic [1:0] {
    HEAD_UP    = 2'd0,
    HEAD_RIGHT = 2'd1,
    HEAD_DOWN  = 2'd2,
    HEAD_LEFT  = 2'd3
  } heading_e;

  localparam logic [HeadW-1:0] ResetHeading = HEAD_LEFT;

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_STEP    = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REG_MAZE_SIZE     = 2'd0,
    REG_START_X       = 2'd1,
    REG_START_Y       = 2'd2,
    REG_START_HEADING = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } pos_t;

  function automatic logic [AddrW-1:0] cell_addr(input logic [CoordW-1:0] x,
                                                 input logic [CoordW-1:0] y);
    logic [CmpW+CmpW-1:0] a;
    begin
      a = (2*CmpW)'(y) * (2*CmpW)'(MazeDim) + (2*CmpW)'(x);
      cell_addr = a[AddrW-1:0];
    end
  endfunction

  function automatic logic [SizeW-1:0] size_in_use(input logic [SizeW-1:0] s);
    begin
      if (s < SizeW'(SizeMin)) begin
        size_in_use = SizeW'(SizeMin);
      end else if (s > SizeW'(SizeCap)) begin
        size_in_use = SizeW'(SizeCap);
      end else begin
        size_in_use = s;
      end
    end
  endfunction

  function automatic logic in_interior(input pos_t p, input logic [SizeW-1:0] s);
    logic [SizeW-1:0] lim;
    begin
      lim = size_in_use(s) - SizeW'(1);
      in_interior = (p.x != '0) && (SizeW'(p.x) < lim) &&
                    (p.y != '0) && (SizeW'(p.y) < lim);
    end
  endfunction

endpackage

[hdl/rhwf_ram.sv]
module rhwf_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/rhwf_step_unit.sv]
module rhwf_step_unit import rhwf_pkg::*; (
  input  pos_t             pos_i,
  input  logic [HeadW-1:0] heading_i,
  output pos_t             next_o,
  output logic [AddrW-1:0] addr_o
);

  always_comb begin
    next_o = pos_i;
    unique case (heading_i)
      HEAD_UP:    next_o.y = pos_i.y - CoordW'(1);
      HEAD_RIGHT: next_o.x = pos_i.x + CoordW'(1);
      HEAD_DOWN:  next_o.y = pos_i.y + CoordW'(1);
      HEAD_LEFT:  next_o.x = pos_i.x - CoordW'(1);
      default:    next_o = pos_i;
    endcase
  end

  assign addr_o = cell_addr(next_o.x, next_o.y);

endmodule

[hdl/right_hand_wall_follower_core.sv]
// channel  | handshake                 | payload
// in       | in_valid_i / in_ready_o   | action_i cell_x_i cell_y_i wall_bit_i
// out      | out_valid_o / out_ready_i | pos_x_o pos_y_o heading_o escaped_o stuck_o
// cfg      | cfg_we_i                  | cfg_idx_i cfg_wdata_i
// A write, restart or idle action goes from accept to the emit state, then into the output registers.
// A step probes the neighbors in the probe state (up to four), one at a time as
// set by the single-port wall memory and its registered read; off the interior it skips them.
// One transaction at a time; in_ready_o is low until the result is loaded.
// A stalled output holds the sequencer in its emit state.
// Reset puts the walker at column 30, row 30, heading left; the wall map is not cleared.
module right_hand_wall_follower_core import rhwf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [SizeW-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic [CoordW-1:0] cell_x_i,
  input  logic [CoordW-1:0] cell_y_i,
  input  logic              wall_bit_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CoordW-1:0] pos_x_o,
  output logic [CoordW-1:0] pos_y_o,
  output logic [HeadW-1:0]  heading_o,
  output logic              escaped_o,
  output logic              stuck_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StProbe = 2'd1;
  localparam logic [1:0] StEmit  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [SizeW-1:0]  size_q;
  logic [CoordW-1:0] start_x_q, start_y_q;
  logic [HeadW-1:0]  start_h_q;
  pos_t              walker_q, walker_d;
  logic [HeadW-1:0]  wheading_q, wheading_d;
  logic [HeadW-1:0]  h_q, h_d;
  logic [1:0]        tries_q, tries_d;
  pos_t              nb_q, nb_d;
  logic              stuck_q, stuck_d;
  logic              out_valid_q, out_valid_d;
  pos_t              out_pos_q;
  logic [HeadW-1:0]  out_h_q;
  logic              out_esc_q, out_stuck_q;
  logic              load_out;

  pos_t              su_next;
  logic [AddrW-1:0]  su_addr;
  logic [HeadW-1:0]  su_h;
  logic              ram_we;
  logic [AddrW-1:0]  ram_addr;
  logic              ram_rdata;
  logic              accept;
  logic              wr_in_range;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == StIdle);
  assign wr_in_range = (CmpW'(cell_x_i) < CmpW'(MazeDim)) &&
                       (CmpW'(cell_y_i) < CmpW'(MazeDim));

  assign su_h = (state_q == StProbe) ? (h_q - HeadW'(1)) : (wheading_q + HeadW'(1));

  rhwf_step_unit u_step (
    .pos_i     (walker_q),
    .heading_i (su_h),
    .next_o    (su_next),
    .addr_o    (su_addr)
  );

  assign ram_we   = accept && (action_i == ACT_WRITE) && wr_in_range;
  assign ram_addr = ram_we ? cell_addr(cell_x_i, cell_y_i) : su_addr;

  rhwf_ram #(
    .Width (1),
    .Depth (MapDepth)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (wall_bit_i),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    walker_d   = walker_q;
    wheading_d = wheading_q;
    h_d        = h_q;
    tries_d    = tries_q;
    nb_d       = nb_q;
    stuck_d    = stuck_q;
    load_out   = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          stuck_d = 1'b0;
          state_d = StEmit;
          unique case (action_i)
            ACT_RESTART: begin
              walker_d.x = start_x_q;
              walker_d.y = start_y_q;
              wheading_d = start_h_q;
            end
            ACT_STEP: begin
              if (in_interior(walker_q, size_q)) begin
                h_d     = su_h;
                tries_d = '0;
                nb_d    = su_next;
                state_d = StProbe;
              end
            end
            default: ;
          endcase
        end
      end
      StProbe: begin
        if (ram_rdata) begin
          if (tries_q == LastTry) begin
            stuck_d = 1'b1;
            state_d = StEmit;
          end else begin
            h_d     = su_h;
            tries_d = tries_q + 2'd1;
            nb_d    = su_next;
          end
        end else begin
          walker_d   = nb_q;
          wheading_d = h_q;
          state_d    = StEmit;
        end
      end
      StEmit: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      size_q      <= ResetSize;
      start_x_q   <= ResetStartX;
      start_y_q   <= ResetStartY;
      start_h_q   <= ResetHeading;
      walker_q.x  <= ResetStartX;
      walker_q.y  <= ResetStartY;
      wheading_q  <= ResetHeading;
      stuck_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      walker_q    <= walker_d;
      wheading_q  <= wheading_d;
      stuck_q     <= stuck_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MAZE_SIZE:     size_q    <= cfg_wdata_i;
          REG_START_X:       start_x_q <= cfg_wdata_i[CoordW-1:0];
          REG_START_Y:       start_y_q <= cfg_wdata_i[CoordW-1:0];
          REG_START_HEADING: start_h_q <= cfg_wdata_i[HeadW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    h_q     <= h_d;
    tries_q <= tries_d;
    nb_q    <= nb_d;
    if (load_out) begin
      out_pos_q   <= walker_q;
      out_h_q     <= wheading_q;
      out_esc_q   <= !in_interior(walker_q, size_q);
      out_stuck_q <= stuck_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_pos_q.x;
  assign pos_y_o     = out_pos_q.y;
  assign heading_o   = out_h_q;
  assign escaped_o   = out_esc_q;
  assign stuck_o     = out_stuck_q;

endmodule
